// ===== hw/rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 8;
    localparam int TICKS_W    = 16;
    localparam int PROD_W     = TICKS_W + TIME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH   = 1'd1;

    localparam logic [COUNT_W-1:0] FOREVER_COUNT = 16'd66;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STEADY = 2'd1,
        OP_BLINK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CHECK = 2'd1,
        PH_LIGHT = 2'd2,
        PH_DARK  = 2'd3
    } t_phase;

    typedef struct packed {
        t_opcode             opcode;
        logic                level_on;
        logic [COUNT_W-1:0]  blink_total;
        logic [TIME_W-1:0]   unit_ticks;
        logic [TIME_W-1:0]   bright_time;
        logic [TIME_W-1:0]   off_time;
    } t_cmd;

    typedef struct packed {
        logic                led_pin;
        logic                blinking;
        logic [COUNT_W-1:0]  blinks_left;
        t_phase              phase;
    } t_res;

    typedef struct packed {
        logic output_enable;
        logic active_high;
    } t_cfg;

endpackage

// ===== hw/rtl/lbc_ifs.sv =====
`timescale 1ns / 1ps

interface lbc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        level_on;
    logic [15:0] blink_total;
    logic [7:0]  unit_ticks;
    logic [7:0]  bright_time;
    logic [7:0]  off_time;

    modport source (output valid, opcode, level_on, blink_total, unit_ticks,
                    bright_time, off_time, input ready);
    modport sink   (input valid, opcode, level_on, blink_total, unit_ticks,
                    bright_time, off_time, output ready);
endinterface

interface lbc_res_if;
    logic        valid;
    logic        ready;
    logic        led_pin;
    logic        blinking;
    logic [15:0] blinks_left;
    logic [1:0]  phase;

    modport source (output valid, led_pin, blinking, blinks_left, phase, input ready);
    modport sink   (input valid, led_pin, blinking, blinks_left, phase, output ready);
endinterface

interface lbc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [0:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lbc_engine.sv =====
`timescale 1ns / 1ps

module lbc_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  lbc_pkg::t_cmd i_cmd,
    input  lbc_pkg::t_cfg i_cfg,
    output lbc_pkg::t_res o_next
);

    logic                         r_pin, n_pin;
    logic                         r_wanted, n_wanted;
    logic                         r_blink, n_blink;
    logic [lbc_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [lbc_pkg::TIME_W-1:0]   r_unit, n_unit;
    logic [lbc_pkg::TIME_W-1:0]   r_bright, n_bright;
    logic [lbc_pkg::TIME_W-1:0]   r_dark, n_dark;
    logic [lbc_pkg::TICKS_W-1:0]  r_lit, n_lit;
    logic [lbc_pkg::TICKS_W-1:0]  r_unlit, n_unlit;
    logic                         r_was_lit, n_was_lit;
    lbc_pkg::t_phase              r_phase, n_phase;

    logic [lbc_pkg::PROD_W-1:0]   w_lit_prod;
    logic [lbc_pkg::PROD_W-1:0]   w_unlit_prod;
    logic                         w_blink_ok;

    function automatic logic [lbc_pkg::TICKS_W-1:0] sat_inc(
        input logic [lbc_pkg::TICKS_W-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    assign w_blink_ok = (i_cmd.blink_total != '0) && (i_cmd.unit_ticks != '0) &&
                        (i_cmd.bright_time != '0) && (i_cmd.off_time != '0);

    always_comb begin
        n_pin     = r_pin;
        n_wanted  = r_wanted;
        n_blink   = r_blink;
        n_count   = r_count;
        n_unit    = r_unit;
        n_bright  = r_bright;
        n_dark    = r_dark;
        n_lit     = r_lit;
        n_unlit   = r_unlit;
        n_was_lit = r_was_lit;
        n_phase   = r_phase;
        w_lit_prod   = '0;
        w_unlit_prod = '0;
        if (i_fire) begin
            case (i_cmd.opcode)
                lbc_pkg::OP_TICK: begin
                    if (i_cfg.output_enable) begin
                        if (r_blink && (r_count != '0)) begin
                            if (r_pin == i_cfg.active_high) begin
                                n_lit     = sat_inc(r_lit);
                                n_unlit   = '0;
                                n_was_lit = 1'b1;
                            end else begin
                                n_lit     = '0;
                                n_unlit   = sat_inc(r_unlit);
                                n_was_lit = 1'b0;
                            end
                        end else if (r_blink) begin
                            n_blink  = 1'b0;
                            n_wanted = ~i_cfg.active_high;
                        end else begin
                            n_lit   = '0;
                            n_unlit = '0;
                        end

                        w_lit_prod   = lbc_pkg::PROD_W'(n_lit) * lbc_pkg::PROD_W'(r_unit);
                        w_unlit_prod = lbc_pkg::PROD_W'(n_unlit) * lbc_pkg::PROD_W'(r_unit);

                        if (r_pin != n_wanted) begin
                            if (!n_blink) begin
                                n_pin = n_wanted;
                            end else begin
                                case (r_phase)
                                    lbc_pkg::PH_IDLE: begin
                                        n_phase = lbc_pkg::PH_CHECK;
                                    end
                                    lbc_pkg::PH_CHECK: begin
                                        n_phase = n_was_lit ? lbc_pkg::PH_LIGHT
                                                            : lbc_pkg::PH_DARK;
                                    end
                                    lbc_pkg::PH_LIGHT: begin
                                        if (w_lit_prod >= lbc_pkg::PROD_W'(r_bright)) begin
                                            n_wanted = ~n_wanted;
                                            n_unlit  = '0;
                                            n_pin    = ~i_cfg.active_high;
                                            if (r_count != lbc_pkg::FOREVER_COUNT) begin
                                                n_count = r_count - 1'b1;
                                            end
                                        end
                                        n_phase = lbc_pkg::PH_IDLE;
                                    end
                                    default: begin
                                        if (w_unlit_prod >= lbc_pkg::PROD_W'(r_dark)) begin
                                            n_wanted = ~n_wanted;
                                            n_lit    = '0;
                                            n_pin    = i_cfg.active_high;
                                        end
                                        n_phase = lbc_pkg::PH_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                end
                lbc_pkg::OP_STEADY: begin
                    n_blink  = 1'b0;
                    n_wanted = i_cmd.level_on ? i_cfg.active_high : ~i_cfg.active_high;
                end
                lbc_pkg::OP_BLINK: begin
                    if (w_blink_ok) begin
                        n_blink  = 1'b1;
                        n_count  = i_cmd.blink_total;
                        n_unit   = i_cmd.unit_ticks;
                        n_bright = i_cmd.bright_time;
                        n_dark   = i_cmd.off_time;
                        n_wanted = ~r_pin;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin     <= 1'b0;
            r_wanted  <= 1'b0;
            r_blink   <= 1'b0;
            r_count   <= '0;
            r_unit    <= lbc_pkg::TIME_W'(1);
            r_bright  <= '0;
            r_dark    <= '0;
            r_lit     <= '0;
            r_unlit   <= '0;
            r_was_lit <= 1'b0;
            r_phase   <= lbc_pkg::PH_IDLE;
        end else begin
            r_pin     <= n_pin;
            r_wanted  <= n_wanted;
            r_blink   <= n_blink;
            r_count   <= n_count;
            r_unit    <= n_unit;
            r_bright  <= n_bright;
            r_dark    <= n_dark;
            r_lit     <= n_lit;
            r_unlit   <= n_unlit;
            r_was_lit <= n_was_lit;
            r_phase   <= n_phase;
        end
    end

    assign o_next.led_pin     = n_pin;
    assign o_next.blinking    = n_blink;
    assign o_next.blinks_left = n_count;
    assign o_next.phase       = n_phase;

    // unit register never holds zero; a zero unit would stall blinking forever
    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unit != '0)
        else $error("unit register is zero");

    a_zero_blink_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.opcode == lbc_pkg::OP_BLINK && !w_blink_ok)
        |=> ($stable(r_count) && $stable(r_blink) && $stable(r_wanted)))
        else $error("blink command with zero argument changed state");

    a_forever_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.opcode == lbc_pkg::OP_TICK && r_count == lbc_pkg::FOREVER_COUNT)
        |=> (r_count == lbc_pkg::FOREVER_COUNT))
        else $error("forever count changed on a tick");

endmodule

// ===== hw/rtl/led_blink_controller_top.sv =====
`timescale 1ns / 1ps

// LED blink controller.
// i_cmd carries one command per beat: tick, steady level or blink setup.
// o_res returns one beat per command: pin level, blink mode, blinks left
// and phase, as they stand after that command.
// i_cfg writes output_enable (index 0) and active_high (index 1), is always
// ready, and must be written only while no command is in flight (unchecked).
// A command accepted into the input register is processed there and
// lands in the result register once o_res can advance; its result is
// valid from then on. Throughput: one command per cycle while o_res does
// not stall; the per-tick update (16x8 product and compare) fits
// between the input and result registers.
// The result register and the input register each hold one beat: when
// o_res stalls, one more command is still taken, then i_cmd.ready drops
// until the result is taken.
// Reset (synchronous, active low) clears both stages, sets both config
// bits to 1, the pin dark at level 0, steady mode and phase idle.

module led_blink_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbc_cmd_if.sink     i_cmd,
    lbc_cfg_if.sink     i_cfg,
    lbc_res_if.source   o_res
);

    logic            r_in_valid;
    lbc_pkg::t_cmd   r_cmd;
    logic            r_out_valid;
    lbc_pkg::t_res   r_res;
    lbc_pkg::t_res   w_next;
    lbc_pkg::t_cfg   r_cfg;
    logic            w_adv;
    logic            w_fire;
    logic            w_in_take;

    assign w_adv     = !r_out_valid || o_res.ready;
    assign w_fire    = r_in_valid && w_adv;
    assign w_in_take = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_enable <= 1'b1;
            r_cfg.active_high   <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lbc_pkg::CFG_OUTPUT_ENABLE: r_cfg.output_enable <= i_cfg.data[0];
                lbc_pkg::CFG_ACTIVE_HIGH:   r_cfg.active_high   <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd.opcode      <= lbc_pkg::t_opcode'(i_cmd.opcode);
            r_cmd.level_on    <= i_cmd.level_on;
            r_cmd.blink_total <= i_cmd.blink_total;
            r_cmd.unit_ticks  <= i_cmd.unit_ticks;
            r_cmd.bright_time <= i_cmd.bright_time;
            r_cmd.off_time    <= i_cmd.off_time;
        end
    end

    lbc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (r_cmd),
        .i_cfg   (r_cfg),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_next;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.led_pin     = r_res.led_pin;
    assign o_res.blinking    = r_res.blinking;
    assign o_res.blinks_left = r_res.blinks_left;
    assign o_res.phase       = r_res.phase;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed command produced no result beat");

    a_held_cmd_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_cmd)))
        else $error("stalled command lost or changed in input register");

    a_steady_ends_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd.opcode == lbc_pkg::OP_STEADY) |=> !r_res.blinking)
        else $error("steady command left blink mode on");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    lbc_cmd_if cmd_if ();
    lbc_cfg_if cfg_if ();
    lbc_res_if res_if ();

    led_blink_controller_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // LED state as the block should hold it
    logic               en_q     = 1'b1;
    logic               pol_q    = 1'b1;
    logic               pin_q    = 1'b0;
    logic               want_q   = 1'b0;
    logic               blink_q  = 1'b0;
    logic [COUNT_W-1:0] left_q   = '0;
    logic [TIME_W-1:0]  unit_q   = 8'd1;
    logic [TIME_W-1:0]  bright_q = '0;
    logic [TIME_W-1:0]  dark_q   = '0;
    logic [TICKS_W-1:0] on_cnt   = '0;
    logic [TICKS_W-1:0] off_cnt  = '0;
    logic               seen_lit = 1'b0;
    t_phase             ph_q     = PH_IDLE;

    t_res status_q[$];

    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int sink_hold   = 0;
    int n_sent      = 0;
    int n_blink     = 0;
    int n_cfg       = 0;
    int n_checked   = 0;
    int n_err       = 0;
    int cyc_cnt     = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cyc_cnt <= cyc_cnt + 1;

    initial begin
        wait (cyc_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results pending", cyc_cnt, status_q.size());
        $display("led_blink_controller_top: mismatch");
        $finish;
    end

    function automatic t_res led_next(input t_cmd c);
        logic              lvl;
        logic [PROD_W-1:0] prod;
        case (c.opcode)
            OP_TICK: begin
                if (en_q) begin
                    lvl = pin_q;
                    if (blink_q && left_q != '0) begin
                        if (lvl == pol_q) begin
                            if (on_cnt != '1) on_cnt = on_cnt + 1'b1;
                            off_cnt  = '0;
                            seen_lit = 1'b1;
                        end else begin
                            on_cnt = '0;
                            if (off_cnt != '1) off_cnt = off_cnt + 1'b1;
                            seen_lit = 1'b0;
                        end
                    end else if (blink_q) begin
                        blink_q = 1'b0;
                        want_q  = ~pol_q;
                    end else begin
                        on_cnt  = '0;
                        off_cnt = '0;
                    end
                    if (lvl != want_q) begin
                        if (!blink_q) begin
                            pin_q = want_q;
                        end else begin
                            case (ph_q)
                                PH_IDLE: ph_q = PH_CHECK;
                                PH_CHECK: ph_q = seen_lit ? PH_LIGHT : PH_DARK;
                                PH_LIGHT: begin
                                    prod = PROD_W'(on_cnt) * PROD_W'(unit_q);
                                    if (prod >= PROD_W'(bright_q)) begin
                                        want_q  = ~want_q;
                                        off_cnt = '0;
                                        pin_q   = ~pol_q;
                                        if (left_q != FOREVER_COUNT) left_q = left_q - 1'b1;
                                    end
                                    ph_q = PH_IDLE;
                                end
                                default: begin
                                    prod = PROD_W'(off_cnt) * PROD_W'(unit_q);
                                    if (prod >= PROD_W'(dark_q)) begin
                                        want_q = ~want_q;
                                        on_cnt = '0;
                                        pin_q  = pol_q;
                                    end
                                    ph_q = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
            OP_STEADY: begin
                blink_q = 1'b0;
                want_q  = c.level_on ? pol_q : ~pol_q;
            end
            OP_BLINK: begin
                if (c.blink_total != '0 && c.unit_ticks != '0 &&
                    c.bright_time != '0 && c.off_time != '0) begin
                    blink_q  = 1'b1;
                    left_q   = c.blink_total;
                    unit_q   = c.unit_ticks;
                    bright_q = c.bright_time;
                    dark_q   = c.off_time;
                    want_q   = ~pin_q;
                end
            end
            default: ;
        endcase
        return '{led_pin: pin_q, blinking: blink_q, blinks_left: left_q, phase: ph_q};
    endfunction

    function automatic t_cmd mk_cmd(input t_opcode op, input logic lvl,
                                    input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] unit,
                                    input logic [TIME_W-1:0] bt, input logic [TIME_W-1:0] dt);
        t_cmd c;
        c.opcode      = op;
        c.level_on    = lvl;
        c.blink_total = cnt;
        c.unit_ticks  = unit;
        c.bright_time = bt;
        c.off_time    = dt;
        return c;
    endfunction

    function automatic t_cmd rand_tick();
        return mk_cmd(OP_TICK, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
    endfunction

    function automatic t_cmd rand_any();
        return mk_cmd(t_opcode'(2'($urandom)), 1'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
    endfunction

    function automatic t_cmd rand_blink();
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  unit;
        logic [TIME_W-1:0]  bt;
        logic [TIME_W-1:0]  dt;
        case ($urandom_range(0, 9))
            6:       cnt = FOREVER_COUNT;
            7:       cnt = 16'($urandom_range(5, 20));
            8, 9:    cnt = 16'($urandom);
            default: cnt = 16'($urandom_range(1, 4));
        endcase
        unit = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 2));
        bt   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 6));
        dt   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 6));
        case ($urandom_range(0, 11))
            0:       cnt  = '0;
            1:       unit = '0;
            2:       bt   = '0;
            3:       dt   = '0;
            default: ;
        endcase
        return mk_cmd(OP_BLINK, 1'($urandom), cnt, unit, bt, dt);
    endfunction

    function automatic int idle_cycles(input bit en);
        return en ? int'($urandom_range(0, 12)) : 0;
    endfunction

    // valid stays high across back-to-back beats
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = idle_cycles(src_idle_en);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.opcode      <= c.opcode;
        cmd_if.level_on    <= c.level_on;
        cmd_if.blink_total <= c.blink_total;
        cmd_if.unit_ticks  <= c.unit_ticks;
        cmd_if.bright_time <= c.bright_time;
        cmd_if.off_time    <= c.off_time;
        cmd_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        status_q.push_back(led_next(c));
        n_sent++;
        if (c.opcode == OP_BLINK) n_blink++;
    endtask

    task automatic wait_results();
        cmd_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        if (idx == CFG_OUTPUT_ENABLE) en_q = val[0];
        else pol_q = val[0];
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic ticks(input int n);
        repeat (n) send_cmd(rand_tick());
    endtask

    task automatic run_random(input int n);
        int stop;
        int sel;
        stop = n_sent + n;
        while (n_sent < stop) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                send_cmd(rand_blink());
                ticks($urandom_range(8, 60));
            end else if (sel < 9) begin
                send_cmd(mk_cmd(OP_STEADY, 1'($urandom), 16'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)));
                ticks($urandom_range(1, 4));
            end else begin
                repeat ($urandom_range(1, 6)) send_cmd(rand_any());
            end
        end
    endtask

    task automatic test_directed();
        write_cfg(CFG_OUTPUT_ENABLE, 1'b1);
        write_cfg(CFG_ACTIVE_HIGH, 1'b1);
        send_cmd(mk_cmd(t_opcode'(OP_RESERVED), 1'b1, '1, '1, '1, '1));
        send_cmd(mk_cmd(OP_STEADY, 1'b1, '0, '0, '0, '0));
        send_cmd(mk_cmd(OP_TICK, 1'b0, '0, '0, '0, '0));
        send_cmd(mk_cmd(OP_STEADY, 1'b0, '1, '1, '1, '1));
        send_cmd(mk_cmd(OP_TICK, 1'b1, '1, '1, '1, '1));
        send_cmd(mk_cmd(OP_BLINK, 1'b0, '0, 8'd1, 8'd1, 8'd1));
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd1, '0, 8'd1, 8'd1));
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd1, 8'd1, '0, 8'd1));
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd1, 8'd1, 8'd1, '0));
        send_cmd(mk_cmd(OP_BLINK, 1'b1, 16'd1, 8'd1, 8'd1, 8'd1));
        ticks(8);
        send_cmd(mk_cmd(OP_BLINK, 1'b1, '1, '1, '1, '1));
        ticks(3);
        send_cmd(mk_cmd(OP_STEADY, 1'b0, '0, '0, '0, '0));
        ticks(2);
    endtask

    task automatic test_forever();
        send_cmd(mk_cmd(OP_BLINK, 1'b0, FOREVER_COUNT, 8'd1, 8'd2, 8'd1));
        ticks(40);
        send_cmd(mk_cmd(OP_STEADY, 1'b0, '0, '0, '0, '0));
        ticks(2);
    endtask

    // commands still land while disabled, ticks do not
    task automatic test_disabled();
        wait_results();
        write_cfg(CFG_OUTPUT_ENABLE, 1'b0);
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd5, 8'd1, 8'd1, 8'd1));
        ticks(6);
        send_cmd(mk_cmd(OP_STEADY, 1'b1, '0, '0, '0, '0));
        ticks(3);
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd2, '0, 8'd1, 8'd1));
        ticks(1);
        wait_results();
        write_cfg(CFG_OUTPUT_ENABLE, 1'b1);
        ticks(3);
    endtask

    task automatic test_random_cfg();
        bit en_tab[5]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        bit pol_tab[5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int p = 0; p < 5; p++) begin
            wait_results();
            write_cfg(CFG_OUTPUT_ENABLE, en_tab[p]);
            write_cfg(CFG_ACTIVE_HIGH, pol_tab[p]);
            src_idle_en = (p != 3);
            snk_idle_en = (p != 3);
            run_random(en_tab[p] ? 100 : 30);
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // sink holds off long enough for the block to back up into i_cmd
    task automatic test_stall_fill();
        wait_results();
        src_idle_en = 1'b0;
        sink_hold   = 80;
        send_cmd(mk_cmd(OP_BLINK, 1'b0, 16'd3, 8'd1, 8'd2, 8'd2));
        ticks(24);
        wait_results();
        ticks(16);
        src_idle_en = 1'b1;
    endtask

    task automatic test_no_idle();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        run_random(100);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    initial begin
        int n;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = (sink_hold > 0) ? sink_hold : idle_cycles(snk_idle_en);
            sink_hold = 0;
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got pin %0b blink %0b left %0h",
                         $time, res_if.led_pin, res_if.blinking, res_if.blinks_left);
                n_err++;
            end else begin
                due = status_q.pop_front();
                n_checked++;
                check_field("led_pin", 16'(due.led_pin), 16'(res_if.led_pin));
                check_field("blinking", 16'(due.blinking), 16'(res_if.blinking));
                check_field("blinks_left", due.blinks_left, res_if.blinks_left);
                check_field("phase", 16'(due.phase), 16'(res_if.phase));
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.opcode      <= '0;
        cmd_if.level_on    <= 1'b0;
        cmd_if.blink_total <= '0;
        cmd_if.unit_ticks  <= '0;
        cmd_if.bright_time <= '0;
        cmd_if.off_time    <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_forever();
        test_disabled();
        test_random_cfg();
        test_stall_fill();
        test_no_idle();

        wait_results();
        $display("sent %0d commands (%0d blink setups), checked %0d status beats", n_sent,
                 n_blink, n_checked);
        $display("across %0d config writes covering both polarities and output gating", n_cfg);
        if (n_err == 0) begin
            $display("led_blink_controller_top: match");
        end else begin
            $display("led_blink_controller_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_ifs.sv
hw/rtl/lbc_engine.sv
hw/rtl/led_blink_controller_top.sv
tb/sv/tb_top.sv
